/* rtl/mppid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mppid_pkg;

  localparam int unsigned DIFF_LIMIT = 1023;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_ERROR_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_SPEED_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_COUNT_LIMIT = 3'd7;

  typedef struct packed {
    logic [11:0] prop_gain;
    logic [10:0] integ_gain;
    logic [9:0]  deriv_gain;
    logic [9:0]  error_limit;
    logic [9:0]  integral_limit;
    logic [15:0] stall_error_limit;
    logic [14:0] stall_speed_limit;
    logic [15:0] stall_count_limit;
  } cfg_t;

  typedef struct packed {
    logic        clear_state;
    logic        ignore_blocking;
    logic        control_enable;
    logic [31:0] target_position;
    logic [15:0] counter_step;
  } step_t;

  typedef struct packed {
    logic        blocked;
    logic        drive_valid;
    logic [15:0] drive_value;
  } result_t;

endpackage

`default_nettype wire

/* rtl/motor_position_pid_with_stall_detect_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// position pid for one motor with stall detection. each input transaction is one control tick:
// it adds counter_step to a wrapping 32-bit shaft position, compares it with target_position,
// counts stall ticks and either runs the saturated pid or, if ignore_blocking is low and the stall
// count passes its limit, clears the loop state and reports blocked with a zero drive. a disabled
// tick gives a zero result and keeps the state unless clear_state is set. one result comes out
// per tick, and a new one is taken every cycle unless the output stalls. the loop state sits in
// single registers updated as the tick leaves the input register. the user must write gains and
// limits through the cfg port only while no tick is in flight; the block does not enforce this.
module motor_position_pid_with_stall_detect_top #(
  parameter int unsigned DiffLimit = mppid_pkg::DIFF_LIMIT
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // counter_step[15:0], target_position[47:16], control_enable[48],
  // ignore_blocking[49], clear_state[50], zero[55:51]
  input  wire  [mppid_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // drive_value[15:0], drive_valid[16], blocked[17], zero[23:18]
  output logic [mppid_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  wire                                cfg_we_i,
  input  wire  [mppid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [mppid_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  mppid_pkg::cfg_t    cfg_q;
  mppid_pkg::step_t   s1_q;
  mppid_pkg::result_t res;
  mppid_pkg::result_t out_q;
  logic               s1_valid_q;
  logic               out_valid_q;
  logic               advance;
  logic               fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && advance;
  assign s_axis_tready = !s1_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain         <= '0;
      cfg_q.integ_gain        <= '0;
      cfg_q.deriv_gain        <= '0;
      cfg_q.error_limit       <= 10'd1023;
      cfg_q.integral_limit    <= 10'd1023;
      cfg_q.stall_error_limit <= '0;
      cfg_q.stall_speed_limit <= '0;
      cfg_q.stall_count_limit <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mppid_pkg::REG_PROP_GAIN:         cfg_q.prop_gain         <= cfg_data_i[11:0];
        mppid_pkg::REG_INTEG_GAIN:        cfg_q.integ_gain        <= cfg_data_i[10:0];
        mppid_pkg::REG_DERIV_GAIN:        cfg_q.deriv_gain        <= cfg_data_i[9:0];
        mppid_pkg::REG_ERROR_LIMIT:       cfg_q.error_limit       <= cfg_data_i[9:0];
        mppid_pkg::REG_INTEGRAL_LIMIT:    cfg_q.integral_limit    <= cfg_data_i[9:0];
        mppid_pkg::REG_STALL_ERROR_LIMIT: cfg_q.stall_error_limit <= cfg_data_i;
        mppid_pkg::REG_STALL_SPEED_LIMIT: cfg_q.stall_speed_limit <= cfg_data_i[14:0];
        mppid_pkg::REG_STALL_COUNT_LIMIT: cfg_q.stall_count_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q <= s_axis_tdata[50:0];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  mppid_core #(
    .DiffLimit(DiffLimit)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cfg_i  (cfg_q),
    .step_i (s1_q),
    .res_o  (res)
  );

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  a_fire_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("tick lost between stages");

  a_idle_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.drive_valid |-> !out_q.blocked && out_q.drive_value == '0)
    else $error("disabled tick produced a drive or blocked flag");

endmodule

`default_nettype wire

/* rtl/mppid_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module mppid_core #(
  parameter int unsigned DiffLimit = mppid_pkg::DIFF_LIMIT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  fire_i,
  input  mppid_pkg::cfg_t      cfg_i,
  input  mppid_pkg::step_t     step_i,
  output mppid_pkg::result_t   res_o
);

  localparam logic signed [11:0] DiffLim = 12'(DiffLimit);

  logic        [31:0] pos_q;
  logic signed [10:0] integ_q;
  logic signed [10:0] prev_q;
  logic        [15:0] stall_q;

  logic        [31:0] pos_base;
  logic signed [10:0] integ_base;
  logic signed [10:0] prev_base;
  logic        [15:0] stall_base;

  logic signed [15:0] step;
  logic        [31:0] pos_d;
  logic signed [31:0] err;
  logic signed [32:0] err_ext;
  logic        [32:0] abs_err;
  logic signed [16:0] step_ext;
  logic        [16:0] abs_step;
  logic               stall_hit;
  logic        [15:0] stall_d;
  logic               blocked_hit;

  logic signed [31:0] err_lim;
  logic signed [10:0] e;
  logic signed [11:0] integ_lim;
  logic signed [11:0] integ_sum;
  logic signed [10:0] integ_d;
  logic signed [11:0] diff_raw;
  logic signed [11:0] diff;
  logic signed [25:0] p_term;
  logic signed [25:0] i_term;
  logic signed [25:0] d_term;
  logic signed [25:0] pid;

  always_comb begin
    pos_base   = step_i.clear_state ? '0 : pos_q;
    integ_base = step_i.clear_state ? '0 : integ_q;
    prev_base  = step_i.clear_state ? '0 : prev_q;
    stall_base = step_i.clear_state ? '0 : stall_q;

    step  = $signed(step_i.counter_step);
    pos_d = pos_base + {{16{step[15]}}, step_i.counter_step};
    err   = $signed(step_i.target_position - pos_d);

    err_ext  = 33'(err);
    abs_err  = err[31] ? 33'(-err_ext) : 33'(err_ext);
    step_ext = 17'(step);
    abs_step = step[15] ? 17'(-step_ext) : 17'(step_ext);

    stall_hit = (abs_err > {17'd0, cfg_i.stall_error_limit}) &&
                (abs_step < {2'd0, cfg_i.stall_speed_limit});
    if (stall_hit) begin
      stall_d = (stall_base == 16'hFFFF) ? stall_base : stall_base + 16'd1;
    end else begin
      stall_d = '0;
    end
    blocked_hit = !step_i.ignore_blocking && (stall_d > cfg_i.stall_count_limit);

    err_lim = $signed({22'd0, cfg_i.error_limit});
    if (err > err_lim) begin
      e = $signed({1'b0, cfg_i.error_limit});
    end else if (err < -err_lim) begin
      e = -$signed({1'b0, cfg_i.error_limit});
    end else begin
      e = err[10:0];
    end

    integ_lim = $signed({2'd0, cfg_i.integral_limit});
    integ_sum = 12'(integ_base) + 12'(e);
    if (integ_sum > integ_lim) begin
      integ_d = integ_lim[10:0];
    end else if (integ_sum < -integ_lim) begin
      integ_d = 11'(-integ_lim);
    end else begin
      integ_d = integ_sum[10:0];
    end

    diff_raw = 12'(e) - 12'(prev_base);
    if (diff_raw > DiffLim) begin
      diff = DiffLim;
    end else if (diff_raw < -DiffLim) begin
      diff = -DiffLim;
    end else begin
      diff = diff_raw;
    end

    p_term = 26'(e) * 26'($signed({1'b0, cfg_i.prop_gain}));
    i_term = 26'(integ_d) * 26'($signed({1'b0, cfg_i.integ_gain}));
    d_term = 26'(diff) * 26'($signed({1'b0, cfg_i.deriv_gain}));
    pid    = p_term + i_term + d_term;

    res_o = '0;
    if (step_i.control_enable) begin
      res_o.drive_valid = 1'b1;
      if (blocked_hit) begin
        res_o.blocked = 1'b1;
      end else begin
        res_o.drive_value = pid[23:8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      integ_q <= '0;
      prev_q  <= '0;
      stall_q <= '0;
    end else if (fire_i) begin
      if (step_i.control_enable) begin
        if (blocked_hit) begin
          pos_q   <= '0;
          integ_q <= '0;
          prev_q  <= '0;
          stall_q <= '0;
        end else begin
          pos_q   <= pos_d;
          integ_q <= integ_d;
          prev_q  <= e;
          stall_q <= stall_d;
        end
      end else if (step_i.clear_state) begin
        pos_q   <= '0;
        integ_q <= '0;
        prev_q  <= '0;
        stall_q <= '0;
      end
    end
  end

  a_blocked_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.blocked |=> pos_q == '0 && integ_q == '0 && prev_q == '0 && stall_q == '0)
    else $error("blocked transaction left state behind");

  a_idle_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !step_i.control_enable && !step_i.clear_state
    |=> $stable(pos_q) && $stable(integ_q) && $stable(prev_q) && $stable(stall_q))
    else $error("disabled transaction changed state");

  a_blocked_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.blocked |-> !step_i.ignore_blocking && res_o.drive_value == '0 && res_o.drive_valid)
    else $error("blocked result with drive or while ignoring blocking");

endmodule

`default_nettype wire

/* bench/motor_position_pid_with_stall_detect_top_test.sv */
`timescale 1ns / 1ps

module motor_position_pid_with_stall_detect_top_test;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // counter_step[15:0], target_position[47:16], control_enable[48],
  // ignore_blocking[49], clear_state[50], zero[55:51]
  logic [mppid_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // drive_value[15:0], drive_valid[16], blocked[17], zero[23:18]
  logic [mppid_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             cfg_we_i = 1'b0;
  logic [mppid_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [mppid_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  motor_position_pid_with_stall_detect_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // controller copy: gains, limits and loop state
  mppid_pkg::cfg_t gains;
  logic [31:0]     shaft_pos;
  longint          integ_acc;
  longint          prev_err;
  logic [15:0]     stall_cnt;

  mppid_pkg::result_t pending_drives[$];
  mppid_pkg::result_t want_res;
  mppid_pkg::result_t got_res;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned ticks_sent = 0;
  int unsigned drives_checked = 0;
  int unsigned blocked_seen = 0;
  int unsigned idle_ticks_seen = 0;
  int unsigned config_phases = 0;
  bit          quiet_mode = 1'b0;
  int          sink_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int srand(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic logic [15:0] pad_junk(logic [15:0] v, int w);
    return v | (16'($urandom) << w);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void clear_loop();
    shaft_pos = '0;
    integ_acc = 0;
    prev_err = 0;
    stall_cnt = '0;
  endfunction

  function automatic mppid_pkg::result_t predict_drive(mppid_pkg::step_t t);
    mppid_pkg::result_t r;
    logic [31:0]        err_bits;
    longint             err_v;
    longint             abs_err;
    longint             abs_step;
    longint             e_v;
    longint             diff_v;
    longint             pid_v;
    logic [63:0]        pid_bits;
    r = '0;
    if (t.clear_state) clear_loop();
    if (!t.control_enable) return r;
    shaft_pos = shaft_pos + {{16{t.counter_step[15]}}, t.counter_step};
    err_bits = t.target_position - shaft_pos;
    err_v = longint'($signed(err_bits));
    abs_err = (err_v < 0) ? -err_v : err_v;
    abs_step = longint'($signed(t.counter_step));
    if (abs_step < 0) abs_step = -abs_step;
    if (abs_err > longint'(gains.stall_error_limit) &&
        abs_step < longint'(gains.stall_speed_limit)) begin
      if (stall_cnt != 16'hFFFF) stall_cnt = stall_cnt + 16'd1;
    end else begin
      stall_cnt = '0;
    end
    if (!t.ignore_blocking && stall_cnt > gains.stall_count_limit) begin
      clear_loop();
      r.drive_valid = 1'b1;
      r.blocked = 1'b1;
      return r;
    end
    e_v = clamp_sym(err_v, longint'(gains.error_limit));
    integ_acc = clamp_sym(integ_acc + e_v, longint'(gains.integral_limit));
    diff_v = clamp_sym(e_v - prev_err, longint'(mppid_pkg::DIFF_LIMIT));
    pid_v = e_v * longint'(gains.prop_gain) + integ_acc * longint'(gains.integ_gain)
          + diff_v * longint'(gains.deriv_gain);
    prev_err = e_v;
    pid_bits = pid_v;
    r.drive_value = pid_bits[23:8];
    r.drive_valid = 1'b1;
    return r;
  endfunction

  function automatic mppid_pkg::step_t mk_tick(logic [15:0] stp, logic [31:0] tgt, logic en,
                                               logic ign, logic clr);
    mppid_pkg::step_t t;
    t.counter_step = stp;
    t.target_position = tgt;
    t.control_enable = en;
    t.ignore_blocking = ign;
    t.clear_state = clr;
    return t;
  endfunction

  // called at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_tick(mppid_pkg::step_t t);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(mppid_pkg::IN_DATA_W - $bits(mppid_pkg::step_t)){1'b0}}, t};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drives.push_back(predict_drive(t));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [mppid_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      mppid_pkg::REG_PROP_GAIN:         gains.prop_gain = data[11:0];
      mppid_pkg::REG_INTEG_GAIN:        gains.integ_gain = data[10:0];
      mppid_pkg::REG_DERIV_GAIN:        gains.deriv_gain = data[9:0];
      mppid_pkg::REG_ERROR_LIMIT:       gains.error_limit = data[9:0];
      mppid_pkg::REG_INTEGRAL_LIMIT:    gains.integral_limit = data[9:0];
      mppid_pkg::REG_STALL_ERROR_LIMIT: gains.stall_error_limit = data[15:0];
      mppid_pkg::REG_STALL_SPEED_LIMIT: gains.stall_speed_limit = data[14:0];
      default:                          gains.stall_count_limit = data[15:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                            logic [15:0] el, logic [15:0] il, logic [15:0] sel,
                            logic [15:0] ssl, logic [15:0] scl);
    write_reg(mppid_pkg::REG_PROP_GAIN, kp);
    write_reg(mppid_pkg::REG_INTEG_GAIN, ki);
    write_reg(mppid_pkg::REG_DERIV_GAIN, kd);
    write_reg(mppid_pkg::REG_ERROR_LIMIT, el);
    write_reg(mppid_pkg::REG_INTEGRAL_LIMIT, il);
    write_reg(mppid_pkg::REG_STALL_ERROR_LIMIT, sel);
    write_reg(mppid_pkg::REG_STALL_SPEED_LIMIT, ssl);
    write_reg(mppid_pkg::REG_STALL_COUNT_LIMIT, scl);
    cfg_we_i <= 1'b0;
    config_phases++;
  endtask

  task automatic test_reset_defaults();
    repeat (6) send_tick(mk_tick(16'($urandom), $urandom, 1'b1, 1'($urandom), 1'b0));
    send_tick(mk_tick(16'h0010, 32'h0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_directed_ticks();
    wait_idle();
    set_config(16'h0100, 16'h0080, 16'h0040, 16'd1023, 16'd500, 16'd1000, 16'd10, 16'd2);
    send_tick(mk_tick(16'h0, 32'h0, 1'b0, 1'b0, 1'b1));
    send_tick(mk_tick(16'h1234, 32'h55AA, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(16'd100, 32'd150, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(-16'sd20, 32'd60, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'h8000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'h7FFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'd5, 32'd5, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(16'h0, 32'h8000_0000, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(16'h0, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1));
    // stall run ending in a blocked tick, then a fresh start
    send_tick(mk_tick(16'h0, 32'd100000, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(16'h0, 32'd100000, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'd3, 32'd100000, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'h0, 32'd100000, 1'b1, 1'b0, 1'b0));
    // blocking ignored, then honoured
    repeat (4) send_tick(mk_tick(-16'sd2, 32'd100000, 1'b1, 1'b1, 1'b0));
    send_tick(mk_tick(16'h0, 32'd100000, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'd10, 32'd100000, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(16'h0, 32'hFFFF_FC00, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_random_phases();
    int               phase;
    int               kind;
    int               len;
    int               offs;
    int               sl;
    int unsigned      phase_end;
    logic [63:0]      rnd_bits;
    mppid_pkg::step_t t;
    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      quiet_mode = (phase % 4 == 3);
      case (phase)
        0: set_config('1, '1, '1, '1, '1, '1, '1, '1);
        1: set_config('0, '0, '0, '0, '0, '0, '0, '0);
        default: begin
          set_config(pad_junk(16'($urandom_range(4095)), 12),
                     pad_junk(16'($urandom_range(2047)), 11),
                     pad_junk(16'($urandom_range(1023)), 10),
                     pad_junk(16'($urandom_range(1023)), 10),
                     pad_junk(16'($urandom_range(1023)), 10),
                     16'($urandom_range(2000)),
                     pad_junk(16'($urandom_range(64)), 15),
                     16'($urandom_range(20)));
        end
      endcase
      phase_end = ticks_sent + 150;
      while (ticks_sent < phase_end) begin
        kind = $urandom_range(9);
        if (kind < 5) begin
          len = $urandom_range(20, 1);
          repeat (len) begin
            t.counter_step = 16'(srand(30));
            t.target_position = shaft_pos + {{16{t.counter_step[15]}}, t.counter_step}
                              + 32'(srand(1500));
            t.control_enable = ($urandom_range(19) != 0);
            t.ignore_blocking = 1'($urandom);
            t.clear_state = ($urandom_range(49) == 0);
            send_tick(t);
          end
        end else if (kind < 8) begin
          len = int'(gains.stall_count_limit) + $urandom_range(3);
          if (len > 40) len = 40;
          repeat (len) begin
            sl = int'(gains.stall_speed_limit);
            t.counter_step = (sl > 1) ? 16'(srand(sl - 1)) : 16'h0;
            offs = int'(gains.stall_error_limit) + 1 + $urandom_range(3000);
            if ($urandom_range(1)) offs = -offs;
            t.target_position = shaft_pos + {{16{t.counter_step[15]}}, t.counter_step}
                              + 32'(offs);
            t.control_enable = ($urandom_range(29) != 0);
            t.ignore_blocking = ($urandom_range(3) == 0);
            t.clear_state = 1'b0;
            send_tick(t);
          end
        end else begin
          len = $urandom_range(5, 1);
          repeat (len) begin
            rnd_bits = {$urandom, $urandom};
            t = rnd_bits[$bits(mppid_pkg::step_t)-1:0];
            send_tick(t);
          end
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = mppid_pkg::result_t'(m_axis_tdata[$bits(mppid_pkg::result_t)-1:0]);
      if (pending_drives.size() == 0) begin
        $error("unexpected result transaction, data %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want_res = pending_drives.pop_front();
        drives_checked++;
        if (got_res.blocked) blocked_seen++;
        if (!got_res.drive_valid) idle_ticks_seen++;
        if (got_res.drive_value !== want_res.drive_value) begin
          $error("drive_value: expected %0d, got %0d",
                 $signed(want_res.drive_value), $signed(got_res.drive_value));
          fail_cnt++;
        end
        if (got_res.drive_valid !== want_res.drive_valid) begin
          $error("drive_valid: expected %0b, got %0b",
                 want_res.drive_valid, got_res.drive_valid);
          fail_cnt++;
        end
        if (got_res.blocked !== want_res.blocked) begin
          $error("blocked: expected %0b, got %0b", want_res.blocked, got_res.blocked);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL motor_position_pid_with_stall_detect_top");
      $finish;
    end
  end

  initial begin
    gains = '0;
    gains.error_limit = 10'd1023;
    gains.integral_limit = 10'd1023;
    clear_loop();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_ticks();
    test_random_phases();
    wait_idle();
    repeat (10) @(negedge clk_i);
    if (pending_drives.size() != 0) begin
      $error("%0d expected results never arrived", pending_drives.size());
      fail_cnt++;
    end
    $display("%0d control ticks over %0d register settings, %0d results checked",
             ticks_sent, config_phases, drives_checked);
    $display("%0d blocked ticks and %0d disabled ticks seen", blocked_seen, idle_ticks_seen);
    if (fail_cnt == 0) begin
      $display("PASS motor_position_pid_with_stall_detect_top");
    end else begin
      $display("FAIL motor_position_pid_with_stall_detect_top");
    end
    $finish;
  end

endmodule
